/* hdl/nmsm_pkg.sv */
package nmsm_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int CORDIC_MAX       = 24;

    localparam logic signed [33:0] CORDIC_X0 = 34'sd652032874;

    typedef enum logic [2:0] {
        REG_TICK      = 3'd0,
        REG_SPEED_G   = 3'd1,
        REG_YAW_G     = 3'd2,
        REG_NOMOTO_G  = 3'd3,
        REG_INV_SPEED = 3'd4,
        REG_RUD_LIM   = 3'd5,
        REG_START_HDG = 3'd6,
        REG_START_SPD = 3'd7
    } reg_idx_t;

    localparam int CFG_IDX_W = 4;

    function automatic logic [31:0] atan_turn(input logic [4:0] i);
        logic [31:0] r;
        begin
            case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2FA;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

endpackage

/* hdl/nmsm_if.sv */
interface nmsm_in_if;
    logic        valid;
    logic        ready;
    logic        restart;
    logic signed [15:0] rudder_cmd;
    logic signed [23:0] speed_cmd;
    modport source (output valid, restart, rudder_cmd, speed_cmd, input ready);
    modport sink   (input valid, restart, rudder_cmd, speed_cmd, output ready);
endinterface

interface nmsm_out_if;
    logic        valid;
    logic        ready;
    logic signed [47:0] east_pos;
    logic signed [47:0] north_pos;
    logic        [31:0] heading_out;
    logic signed [23:0] speed_out;
    logic signed [31:0] yaw_rate_out;
    modport source (output valid, east_pos, north_pos, heading_out, speed_out, yaw_rate_out,
                    input ready);
    modport sink   (input valid, east_pos, north_pos, heading_out, speed_out, yaw_rate_out,
                    output ready);
endinterface

interface nmsm_cfg_if;
    logic        valid;
    logic        ready;
    logic [nmsm_pkg::CFG_IDX_W-1:0] index;
    logic [23:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* hdl/nmsm_mul.sv */
// Shared signed multiplier, 34 x 25 bits, one registered product per cycle.
module nmsm_mul
(
    input  logic               clk,
    input  logic signed [33:0] a,
    input  logic signed [24:0] b,
    output logic signed [58:0] p_reg
);
    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end
endmodule

/* hdl/nomoto_ship_motion_step.sv */
// Nomoto ship motion step.
// Channels: in_ch (restart, rudder_cmd, speed_cmd), out_ch (state after the tick),
// cfg_ch (register index and data, always ready). A transfer on in_ch starts one
// tick; out_ch then presents the result from its own output register, held until
// the receiver takes it.
// Sequence: a restart tick goes from the input transfer straight to the output state. A
// normal tick runs 10 multiplies, each a multiply state and a wait state (the heading wait
// also loads the CORDIC), then the CORDIC rotation steps (CORDIC_STEPS, capped at
// CORDIC_MAX, 16 by default) and the output state. All multiplies pass through one
// registered 34x25 multiplier, and the CORDIC uses one add/shift datapath per step; these
// serial chains set the length of a tick. in_ch is ready again in the cycle after the
// result is loaded, so no new tick is accepted while the previous one is in progress.
// Stalls: the output register parts the two sides, so the next tick may run while a
// result waits; a finished tick holds in its output cycle until out_ch is free.
// Reset: all state (speed, yaw rate, heading, positions) clears to zero and the
// registers take their documented defaults. Config writes are taken any time
// but are meant only while idle.
module nomoto_ship_motion_step #(
    parameter int CORDIC_STEPS = nmsm_pkg::CORDIC_STEPS_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    nmsm_in_if.sink    in_ch,
    nmsm_out_if.source out_ch,
    nmsm_cfg_if.sink   cfg_ch
);
    localparam int NSTEP = (CORDIC_STEPS < nmsm_pkg::CORDIC_MAX) ? CORDIC_STEPS
                                                                  : nmsm_pkg::CORDIC_MAX;

    typedef enum logic [4:0] {
        S_IDLE, S_SPD_M, S_SPD_W, S_EFF_M, S_EFF_W, S_TG1_M, S_TG1_W, S_TG2_M, S_TG2_W,
        S_YAW_M, S_YAW_W, S_HDG_M, S_HDG_W, S_CORD, S_ES_M, S_ES_W, S_ET_M, S_ET_W,
        S_NS_M, S_NS_W, S_NT_M, S_NT_W, S_OUT
    } state_t;

    state_t state_reg;

    // configuration
    logic [15:0] tick_reg, spd_g_reg, yaw_g_reg, nom_g_reg, inv_reg, st_hdg_reg;
    logic [14:0] lim_reg;
    logic signed [23:0] st_spd_reg;

    // model state
    logic signed [23:0] speed_reg;
    logic signed [31:0] yaw_reg;
    logic        [31:0] hdg_reg;
    logic signed [47:0] east_reg, north_reg;

    // output register
    logic signed [47:0] east_o_reg, north_o_reg;
    logic        [31:0] hdg_o_reg;
    logic signed [23:0] speed_o_reg;
    logic signed [31:0] yaw_o_reg;

    // item and scratch
    logic signed [15:0] rud_reg;
    logic signed [23:0] cmd_reg;
    logic signed [33:0] tmp_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic [4:0]         step_reg;
    logic               flip_reg;

    logic signed [33:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [58:0] prod;

    nmsm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_reg(prod));

    assign cfg_ch.ready = 1'b1;
    assign in_ch.ready  = (state_reg == S_IDLE);

    function automatic logic signed [58:0] trunc_shr(input logic signed [58:0] v,
                                                     input int s);
        logic signed [58:0] m;
        begin
            m = v < 0 ? -v : v;
            m = m >>> s;
            return v < 0 ? -m : m;
        end
    endfunction

    // multiplier operand selection
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_SPD_M: begin mul_a = 34'(cmd_reg) - 34'(speed_reg);
                           mul_b = $signed({9'd0, spd_g_reg}); end
            S_EFF_M: begin mul_a = speed_reg < 0 ? -34'(speed_reg) : 34'(speed_reg);
                           mul_b = $signed({9'd0, inv_reg}); end
            S_TG1_M: begin mul_a = tmp_reg; mul_b = $signed({9'd0, nom_g_reg}); end
            S_TG2_M: begin mul_a = tmp_reg; mul_b = 25'(rud_reg); end
            S_YAW_M: begin mul_a = tmp_reg; mul_b = $signed({9'd0, yaw_g_reg}); end
            S_HDG_M: begin mul_a = 34'(yaw_reg); mul_b = $signed({9'd0, tick_reg}); end
            // sine still unflipped here; the flip lands on it as it is multiplied
            S_ES_M:  begin mul_a = flip_reg ? -cy_reg : cy_reg; mul_b = 25'(speed_reg); end
            S_NS_M:  begin mul_a = cx_reg; mul_b = 25'(speed_reg); end
            S_ET_M, S_NT_M: begin mul_a = tmp_reg; mul_b = $signed({9'd0, tick_reg}); end
            default: ;
        endcase
    end

    logic signed [58:0] pt8, pt16, pt30, ssum;
    logic signed [63:0] psum;
    logic [31:0]        hnew, hrot;
    logic signed [33:0] dx, dy;
    logic [31:0]        at;
    always_comb
    begin
        pt8  = trunc_shr(prod, 8);
        pt16 = trunc_shr(prod, 16);
        pt30 = trunc_shr(prod, 30);
        ssum = '0;
        psum = '0;
        hnew = hdg_reg + pt16[31:0];
        hrot = hnew - 32'h80000000;
        dx   = cy_reg >>> step_reg;
        dy   = cx_reg >>> step_reg;
        at   = nmsm_pkg::atan_turn(step_reg);
        unique case (state_reg)
            S_SPD_W: ssum = 59'(speed_reg) + pt16;
            S_YAW_W: ssum = 59'(yaw_reg) + pt16;
            S_ET_W:  psum = 64'(east_reg) + 64'(pt16);
            S_NT_W:  psum = 64'(north_reg) + 64'(pt16);
            default: ;
        endcase
    end

    logic signed [58:0] effv, tgv;
    always_comb
    begin
        effv = prod >>> 12;
        if (effv > 59'sd65536) effv = 59'sd65536;
        tgv = pt8;
        if (tgv > 59'sd2147483647) tgv = 59'sd2147483647;
        else if (tgv < -59'sd2147483648) tgv = -59'sd2147483648;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            out_ch.valid <= 1'b0;
            tick_reg     <= 16'd6554;
            spd_g_reg    <= 16'd655;
            yaw_g_reg    <= 16'd655;
            nom_g_reg    <= 16'd256;
            inv_reg      <= 16'd819;
            lim_reg      <= 15'd6371;
            st_hdg_reg   <= '0;
            st_spd_reg   <= '0;
            speed_reg    <= '0;
            yaw_reg      <= '0;
            hdg_reg      <= '0;
            east_reg     <= '0;
            north_reg    <= '0;
            east_o_reg   <= '0;
            north_o_reg  <= '0;
            hdg_o_reg    <= '0;
            speed_o_reg  <= '0;
            yaw_o_reg    <= '0;
        end
        else
        begin
            if (cfg_ch.valid)
            begin
                unique case (cfg_ch.index)
                    4'(nmsm_pkg::REG_TICK):      tick_reg   <= cfg_ch.data[15:0];
                    4'(nmsm_pkg::REG_SPEED_G):   spd_g_reg  <= cfg_ch.data[15:0];
                    4'(nmsm_pkg::REG_YAW_G):     yaw_g_reg  <= cfg_ch.data[15:0];
                    4'(nmsm_pkg::REG_NOMOTO_G):  nom_g_reg  <= cfg_ch.data[15:0];
                    4'(nmsm_pkg::REG_INV_SPEED): inv_reg    <= cfg_ch.data[15:0];
                    4'(nmsm_pkg::REG_RUD_LIM):   lim_reg    <= cfg_ch.data[14:0];
                    4'(nmsm_pkg::REG_START_HDG): st_hdg_reg <= cfg_ch.data[15:0];
                    4'(nmsm_pkg::REG_START_SPD): st_spd_reg <= $signed(cfg_ch.data);
                    default: ;
                endcase
            end
            // load the output register once it is free, else clear on transfer
            if (state_reg == S_OUT && (!out_ch.valid || out_ch.ready))
            begin
                out_ch.valid <= 1'b1;
                east_o_reg   <= east_reg;
                north_o_reg  <= north_reg;
                hdg_o_reg    <= hdg_reg;
                speed_o_reg  <= speed_reg;
                yaw_o_reg    <= yaw_reg;
            end
            else if (out_ch.valid && out_ch.ready)
                out_ch.valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                    if (in_ch.valid && in_ch.ready)
                    begin
                        if (in_ch.restart)
                        begin
                            speed_reg <= st_spd_reg;
                            hdg_reg   <= {st_hdg_reg, 16'd0};
                            yaw_reg   <= '0;
                            east_reg  <= '0;
                            north_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            // rudder clamp to +/- limit
                            if (17'(in_ch.rudder_cmd) > $signed({2'b0, lim_reg}))
                                rud_reg <= $signed({1'b0, lim_reg});
                            else if (17'(in_ch.rudder_cmd) < -$signed({2'b0, lim_reg}))
                                rud_reg <= -$signed({1'b0, lim_reg});
                            else
                                rud_reg <= in_ch.rudder_cmd;
                            cmd_reg   <= in_ch.speed_cmd;
                            state_reg <= S_SPD_M;
                        end
                    end
                S_SPD_M: state_reg <= S_SPD_W;
                S_SPD_W:
                begin
                    if (ssum > 59'sd8388607) speed_reg <= 24'sh7FFFFF;
                    else if (ssum < -59'sd8388608) speed_reg <= 24'sh800000;
                    else speed_reg <= ssum[23:0];
                    state_reg <= S_EFF_M;
                end
                S_EFF_M: state_reg <= S_EFF_W;
                S_EFF_W: begin tmp_reg <= effv[33:0]; state_reg <= S_TG1_M; end
                S_TG1_M: state_reg <= S_TG1_W;
                S_TG1_W: begin tmp_reg <= prod[33:0]; state_reg <= S_TG2_M; end
                S_TG2_M: state_reg <= S_TG2_W;
                S_TG2_W: begin tmp_reg <= 34'($signed(tgv[31:0])) - 34'(yaw_reg);
                               state_reg <= S_YAW_M; end
                S_YAW_M: state_reg <= S_YAW_W;
                S_YAW_W:
                begin
                    if (ssum > 59'sd2147483647) yaw_reg <= 32'sh7FFFFFFF;
                    else if (ssum < -59'sd2147483648) yaw_reg <= 32'sh80000000;
                    else yaw_reg <= ssum[31:0];
                    state_reg <= S_HDG_M;
                end
                S_HDG_M: state_reg <= S_HDG_W;
                S_HDG_W:
                begin
                    hdg_reg <= hnew;
                    // fold the rear half circle forward, negate results later
                    flip_reg <= (hnew - 32'h40000000) < 32'h80000000;
                    cz_reg <= ((hnew - 32'h40000000) < 32'h80000000)
                              ? 34'($signed(hrot)) : 34'($signed(hnew));
                    cx_reg <= nmsm_pkg::CORDIC_X0;
                    cy_reg <= '0;
                    step_reg <= '0;
                    state_reg <= S_CORD;
                end
                S_CORD:
                begin
                    if (!cz_reg[33])
                    begin
                        cx_reg <= cx_reg - dx; cy_reg <= cy_reg + dy;
                        cz_reg <= cz_reg - 34'(at);
                    end
                    else
                    begin
                        cx_reg <= cx_reg + dx; cy_reg <= cy_reg - dy;
                        cz_reg <= cz_reg + 34'(at);
                    end
                    step_reg <= step_reg + 5'd1;
                    if (32'(step_reg) == NSTEP - 1)
                        state_reg <= S_ES_M;
                    else if (NSTEP == 0)
                        state_reg <= S_ES_M;
                end
                S_ES_M:
                begin
                    if (flip_reg) begin cx_reg <= -cx_reg; cy_reg <= -cy_reg; end
                    state_reg <= S_ES_W;
                end
                S_ES_W: begin tmp_reg <= pt30[33:0]; state_reg <= S_ET_M; end
                S_ET_M: state_reg <= S_ET_W;
                S_ET_W:
                begin
                    if (psum > 64'sh7FFFFFFFFFFF) east_reg <= 48'sh7FFFFFFFFFFF;
                    else if (psum < -64'sh800000000000) east_reg <= 48'sh800000000000;
                    else east_reg <= psum[47:0];
                    state_reg <= S_NS_M;
                end
                S_NS_M: state_reg <= S_NS_W;
                S_NS_W: begin tmp_reg <= pt30[33:0]; state_reg <= S_NT_M; end
                S_NT_M: state_reg <= S_NT_W;
                S_NT_W:
                begin
                    if (psum > 64'sh7FFFFFFFFFFF) north_reg <= 48'sh7FFFFFFFFFFF;
                    else if (psum < -64'sh800000000000) north_reg <= 48'sh800000000000;
                    else north_reg <= psum[47:0];
                    state_reg <= S_OUT;
                end
                S_OUT:
                    if (!out_ch.valid || out_ch.ready)
                        state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign out_ch.east_pos     = east_o_reg;
    assign out_ch.north_pos    = north_o_reg;
    assign out_ch.heading_out  = hdg_o_reg;
    assign out_ch.speed_out    = speed_o_reg;
    assign out_ch.yaw_rate_out = yaw_o_reg;

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !in_ch.ready) else $error("ready while busy");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> $stable(east_o_reg) && out_ch.valid)
        else $error("result changed under stall");
    a_start: assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> (state_reg != S_IDLE))
        else $error("transfer not started");
endmodule
